// File: rtl/core/multicolor_cell_pixel_store_core_macros.svh
// ---------------------------------------------------------------------------
// multicolor cell pixel store assertion macros
// shared concurrent assertion forms, sampled on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef MULTICOLOR_CELL_PIXEL_STORE_CORE_MACROS_SVH
`define MULTICOLOR_CELL_PIXEL_STORE_CORE_MACROS_SVH

// same-cycle implication
`define MCPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcps assertion failed");

// next-cycle implication
`define MCPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcps assertion failed");

`endif

// File: rtl/core/mcps_pkg.sv
// ---------------------------------------------------------------------------
// mcps_pkg
// types and constants of the multicolor cell pixel store
// ---------------------------------------------------------------------------
package mcps_pkg;

    localparam int CELL_COLUMNS_DEF = 40;
    localparam int CELL_ROWS_DEF    = 25;

    localparam int COLOR_W      = 4;
    localparam int COORD_W      = 8;
    localparam int SLOT_W       = 2;
    localparam int SLOT_CNT     = 3;
    localparam int SLOT_FIELD_W = 5;
    localparam int CELL_PIXELS  = 32;
    localparam int BITMAP_W     = 2 * CELL_PIXELS;
    localparam int SLOTS_W      = SLOT_CNT * SLOT_FIELD_W;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_BG   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COLOR_W-1:0] color;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [SLOT_W-1:0]  slot_used;
        logic               in_range;
    } result_t;

endpackage

// File: rtl/core/multicolor_cell_pixel_store_core.sv
// ---------------------------------------------------------------------------
// multicolor cell pixel store core
// Takes one item transfer per cycle while item_stall is low. An item accepted
// at a clock edge reads its cell word from the bitmap and slot-colour memories
// at that edge; when stage s1 advances, the modified word is written back and
// the result lands in the output register; a one-entry forward path of the
// last written word lets back-to-back items hit the same cell. The single
// read-modify-write per cell sets this rate; output stall holds the item in
// s1. After reset a clearing pass over all CELL_COLUMNS * CELL_ROWS cells
// (1000 by default) zeroes both memories while items stall; bg writes are taken.
// ---------------------------------------------------------------------------
`include "multicolor_cell_pixel_store_core_macros.svh"

module multicolor_cell_pixel_store_core #(
    parameter int CELL_COLUMNS = mcps_pkg::CELL_COLUMNS_DEF,
    parameter int CELL_ROWS    = mcps_pkg::CELL_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mcps_pkg::COLOR_W-1:0]   cfg_wdata,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  mcps_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output mcps_pkg::result_t              result
);

    localparam int CELL_COUNT = CELL_COLUMNS * CELL_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int IDX_W      = 12;
    localparam logic [mcps_pkg::COORD_W:0]   X_LIMIT   = 9'(4 * CELL_COLUMNS);
    localparam logic [mcps_pkg::COORD_W+1:0] Y_LIMIT   = 10'(8 * CELL_ROWS);
    localparam logic [ADDR_W-1:0]            LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

    localparam int BW = mcps_pkg::BITMAP_W;
    localparam int SW = mcps_pkg::SLOTS_W;
    localparam int FW = mcps_pkg::SLOT_FIELD_W;
    localparam int CW = mcps_pkg::COLOR_W;

    // memories
    logic [BW-1:0] bitmap_mem [CELL_COUNT];
    logic [SW-1:0] slots_mem  [CELL_COUNT];

    logic [CW-1:0]     bg_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic              s1_in_range_reg;
    logic [4:0]        s1_pix_reg;
    logic [CW-1:0]     s1_color_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [BW-1:0]     bm_rd_reg;
    logic [SW-1:0]     sc_rd_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [BW-1:0]     fwd_bm_reg;
    logic [SW-1:0]     fwd_sc_reg;

    logic              result_valid_reg;
    logic              result_valid_next;
    mcps_pkg::result_t result_reg;
    mcps_pkg::result_t result_next;

    logic              item_accept;
    logic              in_range_in;
    logic [IDX_W-1:0]  cell_full;
    logic [ADDR_W-1:0] in_addr;
    logic              s1_adv;
    logic              fwd_hit;
    logic [BW-1:0]     cur_bm;
    logic [SW-1:0]     cur_sc;
    logic [2:0]        used;
    logic [SW-1:0]     freed;
    logic [SW-1:0]     new_sc;
    logic [BW-1:0]     new_bm;
    logic [1:0]        cur_slot;
    logic [1:0]        winner;
    logic              found;
    logic              take_new;
    logic [CW-1:0]     rd_color;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [BW-1:0]     mem_bm;
    logic [SW-1:0]     mem_sc;

    // input side
    assign item_accept = item_valid && !item_stall;
    assign in_range_in = ({1'b0, item.x_pos} < X_LIMIT) && ({2'b00, item.y_pos} < Y_LIMIT);
    assign cell_full   = IDX_W'(item.x_pos[7:2])
                       + IDX_W'(CELL_COLUMNS) * IDX_W'(item.y_pos[7:3]);
    assign in_addr     = cell_full[ADDR_W-1:0];

    assign s1_adv     = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = clearing_reg || (s1_valid_reg && !s1_adv);

    // forward the last written word
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
    assign cur_bm  = fwd_hit ? fwd_bm_reg : bm_rd_reg;
    assign cur_sc  = fwd_hit ? fwd_sc_reg : sc_rd_reg;

    // cell update
    always_comb
    begin
        cur_slot = cur_bm[{s1_pix_reg, 1'b0} +: 2];

        used = '0;
        for (int p = 0; p < mcps_pkg::CELL_PIXELS; p++)
        begin
            for (int k = 0; k < mcps_pkg::SLOT_CNT; k++)
            begin
                if (cur_bm[2*p +: 2] == 2'(k + 1))
                begin
                    used[k] = 1'b1;
                end
            end
        end

        freed = cur_sc;
        for (int k = 0; k < mcps_pkg::SLOT_CNT; k++)
        begin
            if (!used[k])
            begin
                freed[k*FW +: FW] = '0;
            end
        end

        winner = mcps_pkg::SLOT_BG;
        found  = (s1_color_reg == bg_reg);
        for (int k = 0; k < mcps_pkg::SLOT_CNT; k++)
        begin
            if (!found && (freed[k*FW +: FW] == {1'b1, s1_color_reg}))
            begin
                winner = 2'(k + 1);
                found  = 1'b1;
            end
        end
        take_new = !found;
        for (int k = 0; k < mcps_pkg::SLOT_CNT; k++)
        begin
            if (!found && !freed[k*FW + CW])
            begin
                winner = 2'(k + 1);
                found  = 1'b1;
            end
        end
        if (!found)
        begin
            winner = (cur_slot == mcps_pkg::SLOT_BG) ? mcps_pkg::SLOT_LAST : cur_slot;
        end

        new_sc = freed;
        for (int k = 0; k < mcps_pkg::SLOT_CNT; k++)
        begin
            if (take_new && (winner == 2'(k + 1)))
            begin
                new_sc[k*FW +: FW] = {1'b1, s1_color_reg};
            end
        end

        new_bm = cur_bm;
        new_bm[{s1_pix_reg, 1'b0} +: 2] = winner;

        rd_color = bg_reg;
        for (int k = 0; k < mcps_pkg::SLOT_CNT; k++)
        begin
            if (cur_slot == 2'(k + 1))
            begin
                rd_color = cur_sc[k*FW + CW] ? cur_sc[k*FW +: CW] : '0;
            end
        end

        if (!s1_in_range_reg)
        begin
            result_next = '0;
        end
        else if (s1_mode_reg == mcps_pkg::MODE_READ)
        begin
            result_next = '{pixel_color: rd_color, slot_used: cur_slot, in_range: 1'b1};
        end
        else
        begin
            result_next = '{pixel_color: s1_color_reg, slot_used: winner, in_range: 1'b1};
        end
    end

    always_comb
    begin
        if (s1_adv)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // write port
    assign mem_we   = clearing_reg
                   || (s1_adv && s1_in_range_reg && (s1_mode_reg == mcps_pkg::MODE_WRITE));
    assign mem_addr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_bm   = clearing_reg ? '0 : new_bm;
    assign mem_sc   = clearing_reg ? '0 : new_sc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_addr] <= mem_bm;
            slots_mem[mem_addr]  <= mem_sc;
        end
        if (item_accept)
        begin
            bm_rd_reg <= bitmap_mem[in_addr];
            sc_rd_reg <= slots_mem[in_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg           <= '0;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bg_reg <= cfg_wdata;
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (item_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_we && !clearing_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_mode_reg     <= item.mode;
            s1_in_range_reg <= in_range_in;
            s1_pix_reg      <= {item.y_pos[2:0], item.x_pos[1:0]};
            s1_color_reg    <= item.color;
            s1_addr_reg     <= in_addr;
        end
        if (mem_we && !clearing_reg)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_bm_reg   <= new_bm;
            fwd_sc_reg   <= new_sc;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `MCPS_ASSERT_IMP(a_no_item_in_clear, clearing_reg, !s1_valid_reg && !result_valid_reg)
    `MCPS_ASSERT_IMP(a_write_source, mem_we, clearing_reg || (s1_adv && s1_in_range_reg))
    `MCPS_ASSERT_NXT(a_out_of_range_zero, s1_adv && !s1_in_range_reg,
                     result_valid_reg && (result_reg == '0))
    `MCPS_ASSERT_NXT(a_forward_tracks_write,
                     s1_adv && s1_in_range_reg && (s1_mode_reg == mcps_pkg::MODE_WRITE),
                     fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)))

endmodule
